/* design/fspc_pkg.sv */
package fspc_pkg;

    // Output format codes
    localparam logic [2:0] FMT_INT16 = 3'd0;
    localparam logic [2:0] FMT_INT24 = 3'd1;
    localparam logic [2:0] FMT_INT32 = 3'd2;
    localparam logic [2:0] FMT_F32   = 3'd3;
    localparam logic [2:0] FMT_F64   = 3'd4;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_FORMAT = 2'd0;
    localparam logic [1:0] REG_ENDIAN = 2'd1;
    localparam logic [1:0] REG_CLAMP  = 2'd2;

    // Double precision scale factors (2^(N-1)-1 + 0.49999) as 53-bit
    // significands; value = M * 2^-K.
    localparam logic [52:0] SCALE16_M = 53'd9007061813038741;
    localparam logic [52:0] SCALE24_M = 53'd9007198717859343;
    localparam logic [52:0] SCALE32_M = 53'd9007199252643798;
    localparam logic [5:0]  SCALE16_K = 6'd38;
    localparam logic [5:0]  SCALE24_K = 6'd30;
    localparam logic [5:0]  SCALE32_K = 6'd22;

    typedef struct packed {
        logic [31:0] sample_bits;
        logic        end_of_block;
    } t_in_item;

    typedef struct packed {
        logic [63:0] packed_bytes;
        logic [3:0]  byte_count;
        logic        overflow;
        logic        end_of_block_out;
    } t_out_item;

    typedef struct packed {
        logic [2:0] fmt;
        logic       big_endian;
        logic       clamp_en;
    } t_cfg;

    // Converted value ahead of byte packing
    typedef struct packed {
        logic [63:0] val;
        logic [2:0]  fmt;
        logic        big_endian;
        logic        overflow;
        logic        eob;
    } t_conv_item;

endpackage

/* design/fspc_apb_regs.sv */
module fspc_apb_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [3:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready,
    output fspc_pkg::t_cfg o_cfg
);
    import fspc_pkg::*;

    logic [2:0] r_fmt;
    logic       r_big_endian;
    logic       r_clamp_en;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt        <= FMT_INT16;
            r_big_endian <= 1'b0;
            r_clamp_en   <= 1'b1;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_FORMAT: r_fmt        <= pwdata[2:0];
                REG_ENDIAN: r_big_endian <= pwdata[0];
                REG_CLAMP:  r_clamp_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_FORMAT: prdata = {29'b0, r_fmt};
            REG_ENDIAN: prdata = {31'b0, r_big_endian};
            REG_CLAMP:  prdata = {31'b0, r_clamp_en};
            default:    prdata = 32'b0;
        endcase
    end

    assign o_cfg = '{fmt: r_fmt, big_endian: r_big_endian, clamp_en: r_clamp_en};

endmodule

/* design/fspc_scale.sv */
module fspc_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  fspc_pkg::t_in_item   i_item,
    input  fspc_pkg::t_cfg       i_cfg,
    output logic                 o_valid,
    output fspc_pkg::t_conv_item o_conv
);
    import fspc_pkg::*;

    // valid bits for stages 1..6
    logic [6:1] r_v;

    // side band carried through stages 1..5
    typedef struct packed {
        logic [31:0] raw;
        logic [2:0]  fmt;
        logic        big_endian;
        logic        eob;
        logic        sign;
        logic        nan;
        logic        zero;
    } t_side;

    t_side r_sd1, r_sd2, r_sd3, r_sd4, r_sd5;

    // ---- stage 1: decode, clamp, scale select, subnormal lead count
    logic [31:0] n_bits;
    logic [52:0] n_mant;
    logic [5:0]  n_k;
    logic [4:0]  n_lzs;
    logic [4:0]  lead;
    logic [7:0]  n_e;
    t_side       n_sd1;

    logic [23:0] r_s1_m;
    logic [7:0]  r_s1_e;
    logic [52:0] r_s1_mant;
    logic [5:0]  r_s1_k;
    logic [4:0]  r_s1_lzs;

    always_comb begin
        n_bits = i_item.sample_bits;
        if (i_cfg.clamp_en && (i_item.sample_bits[30:0] > 31'h3F80_0000)) begin
            n_bits = {i_item.sample_bits[31], 31'h3F80_0000};
        end
        n_e = n_bits[30:23];
        case (i_cfg.fmt)
            FMT_INT16: begin
                n_mant = SCALE16_M;
                n_k    = SCALE16_K;
            end
            FMT_INT24: begin
                n_mant = SCALE24_M;
                n_k    = SCALE24_K;
            end
            default: begin
                n_mant = SCALE32_M;
                n_k    = SCALE32_K;
            end
        endcase
        lead = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (i_item.sample_bits[i]) lead = 5'(i);
        end
        n_lzs = 5'd23 - lead;
        n_sd1.raw        = i_item.sample_bits;
        n_sd1.fmt        = i_cfg.fmt;
        n_sd1.big_endian = i_cfg.big_endian;
        n_sd1.eob        = i_item.end_of_block;
        n_sd1.sign       = i_item.sample_bits[31];
        n_sd1.nan        = (i_item.sample_bits[30:23] == 8'hFF) &&
                           (i_item.sample_bits[22:0] != 23'b0);
        // below 2^-32 the scaled value truncates to zero
        n_sd1.zero       = n_e < 8'd95;
    end

    always_ff @(posedge i_clk) begin
        r_s1_m    <= {1'b1, n_bits[22:0]};
        r_s1_e    <= n_e;
        r_s1_mant <= n_mant;
        r_s1_k    <= n_k;
        r_s1_lzs  <= n_lzs;
        r_sd1     <= n_sd1;
    end

    // ---- stage 2: partial products, shift base, float64 widening
    logic [50:0]       r_s2_pplo;
    logic [49:0]       r_s2_pphi;
    logic signed [9:0] r_s2_sh;
    logic [63:0]       r_s2_wide;
    logic [63:0]       n_wide;
    logic [23:0]       wsh;
    logic [10:0]       wex;

    always_comb begin
        wsh = 24'({1'b0, r_sd1.raw[22:0]}) << r_s1_lzs;
        wex = 11'd897 - 11'(r_s1_lzs);
        if (r_sd1.raw[30:23] == 8'hFF) begin
            n_wide = {r_sd1.raw[31], 11'h7FF, r_sd1.raw[22:0], 29'b0};
        end else if (r_sd1.raw[30:23] == 8'h00) begin
            if (r_sd1.raw[22:0] == 23'b0) begin
                n_wide = {r_sd1.raw[31], 63'b0};
            end else begin
                n_wide = {r_sd1.raw[31], wex, wsh[22:0], 29'b0};
            end
        end else begin
            n_wide = {r_sd1.raw[31], 11'(r_sd1.raw[30:23]) + 11'd896,
                      r_sd1.raw[22:0], 29'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_pplo <= {27'b0, r_s1_m} * {24'b0, r_s1_mant[26:0]};
        r_s2_pphi <= {26'b0, r_s1_m} * {24'b0, r_s1_mant[52:27]};
        r_s2_sh   <= 10'sd127 + signed'({4'b0, r_s1_k}) - signed'({2'b0, r_s1_e});
        r_s2_wide <= n_wide;
        r_sd2     <= r_sd1;
    end

    // ---- stage 3: full product
    logic [76:0]       r_s3_p;
    logic signed [9:0] r_s3_sh;
    logic [63:0]       r_s3_wide;

    always_ff @(posedge i_clk) begin
        r_s3_p    <= {r_s2_pphi, 27'b0} + {26'b0, r_s2_pplo};
        r_s3_sh   <= r_s2_sh;
        r_s3_wide <= r_s2_wide;
        r_sd3     <= r_sd2;
    end

    // ---- stage 4: round to 53 bits, nearest even
    logic [52:0]       keep;
    logic              guard, sticky;
    logic [53:0]       r_s4_r;
    logic signed [9:0] r_s4_sh;
    logic [63:0]       r_s4_wide;

    always_comb begin
        if (r_s3_p[76]) begin
            keep   = r_s3_p[76:24];
            guard  = r_s3_p[23];
            sticky = |r_s3_p[22:0];
        end else begin
            keep   = r_s3_p[75:23];
            guard  = r_s3_p[22];
            sticky = |r_s3_p[21:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_r    <= {1'b0, keep} + {53'b0, guard & (sticky | keep[0])};
        r_s4_sh   <= r_s3_sh - signed'({9'b0, r_s3_p[76]});
        r_s4_wide <= r_s3_wide;
        r_sd4     <= r_sd3;
    end

    // ---- stage 5: truncate to integer magnitude
    logic [32:0] n_mag;
    logic [53:0] shifted;
    logic [32:0] r_s5_mag;
    logic        r_s5_big;
    logic [63:0] r_s5_wide;

    always_comb begin
        shifted = r_s4_r >> r_s4_sh[5:0];
        n_mag   = (r_s4_sh > 10'sd53) ? 33'b0 : shifted[32:0];
    end

    always_ff @(posedge i_clk) begin
        r_s5_mag  <= n_mag;
        // |y| >= 2^32 here, beyond every target range
        r_s5_big  <= r_s4_sh < 10'sd21;
        r_s5_wide <= r_s4_wide;
        r_sd5     <= r_sd4;
    end

    // ---- stage 6: saturate, sign, select by format
    logic [32:0]  lim;
    logic [32:0]  v;
    logic         ovf;
    logic         is_int;
    t_conv_item   n_conv;
    t_conv_item   r_s6;

    always_comb begin
        case (r_sd5.fmt)
            FMT_INT16: lim = 33'h0_0000_8000;
            FMT_INT24: lim = 33'h0_0080_0000;
            default:   lim = 33'h0_8000_0000;
        endcase
        is_int = (r_sd5.fmt == FMT_INT16) || (r_sd5.fmt == FMT_INT24) ||
                 (r_sd5.fmt == FMT_INT32);
        ovf = 1'b0;
        if (r_sd5.nan || r_sd5.zero) begin
            v = 33'b0;
        end else if (r_s5_big || (!r_sd5.sign && r_s5_mag >= lim)) begin
            v   = r_sd5.sign ? -lim : lim - 33'd1;
            ovf = 1'b1;
        end else if (r_sd5.sign && r_s5_mag >= lim + 33'd1) begin
            v   = -lim;
            ovf = 1'b1;
        end else begin
            v = r_sd5.sign ? -r_s5_mag : r_s5_mag;
        end
        v = v & ((lim << 1) - 33'd1);

        n_conv.fmt        = r_sd5.fmt;
        n_conv.big_endian = r_sd5.big_endian;
        n_conv.eob        = r_sd5.eob;
        n_conv.overflow   = is_int & ovf;
        if (is_int) begin
            n_conv.val = {32'b0, v[31:0]};
        end else if (r_sd5.fmt == FMT_F64) begin
            n_conv.val = r_s5_wide;
        end else begin
            n_conv.val = {32'b0, r_sd5.raw};
        end
    end

    always_ff @(posedge i_clk) begin
        r_s6 <= n_conv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[5:1], i_valid};
        end
    end

    assign o_valid = r_v[6];
    assign o_conv  = r_s6;

`ifndef SYNTH
    a_ovf_int_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[6] && r_s6.overflow |-> r_s6.fmt == FMT_INT16 ||
            r_s6.fmt == FMT_INT24 || r_s6.fmt == FMT_INT32)
        else $error("overflow on a float format");
    a_nan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] && r_sd5.nan && r_sd5.fmt == FMT_INT16 |=>
            r_s6.val == 64'b0 && !r_s6.overflow)
        else $error("NaN did not give zero");
    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[4] |-> r_s4_r[53:52] != 2'b00)
        else $error("rounded significand lost its lead bit");
`endif

endmodule

/* design/fspc_pack.sv */
module fspc_pack (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  fspc_pkg::t_conv_item i_conv,
    output logic                 o_valid,
    output fspc_pkg::t_out_item  o_item
);
    import fspc_pkg::*;

    logic [63:0] v;
    logic [63:0] swapped;
    logic [3:0]  n_count;
    t_out_item   r_item;
    logic        r_valid;

    always_comb begin
        v = i_conv.val;
        case (i_conv.fmt)
            FMT_INT16: begin
                n_count = 4'd2;
                swapped = {48'b0, v[7:0], v[15:8]};
            end
            FMT_INT24: begin
                n_count = 4'd3;
                swapped = {40'b0, v[7:0], v[15:8], v[23:16]};
            end
            FMT_F64: begin
                n_count = 4'd8;
                swapped = {v[7:0], v[15:8], v[23:16], v[31:24],
                           v[39:32], v[47:40], v[55:48], v[63:56]};
            end
            default: begin
                n_count = 4'd4;
                swapped = {32'b0, v[7:0], v[15:8], v[23:16], v[31:24]};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item.packed_bytes     <= i_conv.big_endian ? swapped : v;
        r_item.byte_count       <= n_count;
        r_item.overflow         <= i_conv.overflow;
        r_item.end_of_block_out <= i_conv.eob;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

`ifndef SYNTH
    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_item.byte_count == 4'd2 || r_item.byte_count == 4'd3 ||
            r_item.byte_count == 4'd4 || r_item.byte_count == 4'd8)
        else $error("bad byte count");
    a_upper_zero16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.byte_count == 4'd2 |-> r_item.packed_bytes[63:16] == 48'b0)
        else $error("bytes beyond count");
    a_upper_zero24: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.byte_count == 4'd3 |-> r_item.packed_bytes[63:24] == 40'b0)
        else $error("bytes beyond count");
    a_ovf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_item.overflow |-> r_item.byte_count != 4'd8)
        else $error("overflow with float64");
`endif

endmodule

/* design/float_sample_to_pcm_converter_unit.sv */
// A sample on start goes through stages 1-6 and the pack register to o_valid.
// Throughput: one sample per cycle; busy stays low, seven samples in flight.
// Depth set by the split 24x53 scale multiply, 77-bit sum, rounding and shift.
// Reset (i_rst_n low, synchronous): pipeline valids clear, registers return
// to int16, little endian, clamp on. The receiver cannot stall the output.
module float_sample_to_pcm_converter_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // sample input
    input  logic                start,
    output logic                busy,
    input  fspc_pkg::t_in_item  i_in_item,
    // result output, one-cycle strobe
    output logic                o_valid,
    output fspc_pkg::t_out_item o_out_item
);
    import fspc_pkg::*;

    t_cfg       cfg;
    t_conv_item conv;
    logic       conv_valid;
    logic       accept;

    // Every stage advances each cycle, so the block never refuses an item.
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    fspc_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Stages 1-6: decode/clamp, partial products, product sum, round,
    // truncate, saturate and format select. Config is sampled at entry.
    fspc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_item  (i_in_item),
        .i_cfg   (cfg),
        .o_valid (conv_valid),
        .o_conv  (conv)
    );

    // Stage 7: byte order and byte count into the output register.
    fspc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (conv_valid),
        .i_conv  (conv),
        .o_valid (o_valid),
        .o_item  (o_out_item)
    );

endmodule

/* tb/sv/tb_float_sample_to_pcm_converter_unit.sv */
`timescale 1ns / 1ps

module tb_float_sample_to_pcm_converter_unit;
    import fspc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    // Pipeline depth from the top-level notes is 7; leave some margin.
    localparam int DRAIN_CYCLES = 12;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    t_in_item    i_in_item = '0;
    logic        o_valid;
    t_out_item   o_out_item;

    // Our own copy of the register set, kept in step with APB writes.
    logic [2:0]  fmt_reg = FMT_INT16;
    logic        be_reg = 1'b0;
    logic        clamp_reg = 1'b1;

    t_out_item   pcm_expected[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic        busy_at_edge;

    always #4 i_clk = ~i_clk;

    float_sample_to_pcm_converter_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .start      (start),
        .busy       (busy),
        .i_in_item  (i_in_item),
        .o_valid    (o_valid),
        .o_out_item (o_out_item)
    );

    // busy and o_valid only move at rising edges; taking them at the falling
    // edge gives the value that the next rising edge sees, free of races.
    always @(negedge i_clk) begin
        busy_at_edge <= busy;
    end

    // Decode a float32 pattern to a real; finite values are exact.
    function automatic real f32_value(logic [31:0] b);
        real mag;
        if (b[30:23] == 8'hFF)
            mag = 1.0e300;
        else if (b[30:23] == 8'd0)
            mag = real'(b[22:0]) * (2.0 ** (-149.0));
        else
            mag = real'({1'b1, b[22:0]}) * (2.0 ** (real'(b[30:23]) - 150.0));
        return b[31] ? -mag : mag;
    endfunction

    // Clamp (when enabled), scale, truncate toward zero and saturate to a signed width; NaN gives zero.
    function automatic logic [63:0] scale_to_pcm(logic [31:0] b, real gain, int bits,
                                                 output logic sat);
        real    x;
        real    y;
        longint top;
        longint bottom;
        longint r;
        top = (longint'(1) << (bits - 1)) - 1;
        bottom = -top - 1;
        sat = 1'b0;
        if (b[30:23] == 8'hFF && b[22:0] != 0)
            return '0;
        x = f32_value(b);
        if (clamp_reg) begin
            if (x > 1.0) x = 1.0;
            if (x < -1.0) x = -1.0;
        end
        y = x * gain;
        if (y >= real'(top) + 1.0) begin
            r = top;
            sat = 1'b1;
        end else if (y <= real'(bottom) - 1.0) begin
            r = bottom;
            sat = 1'b1;
        end else begin
            r = longint'($rtoi(y));
        end
        return 64'(r) & ((64'd1 << bits) - 1);
    endfunction

    // Exact single to double widening on the bit pattern.
    function automatic logic [63:0] widen_to_f64(logic [31:0] b);
        logic [63:0] sgn;
        logic [63:0] frac;
        int          ex;
        sgn = {b[31], 63'd0};
        frac = {41'd0, b[22:0]};
        if (b[30:23] == 8'hFF)
            return sgn | (64'h7FF << 52) | (frac << 29);
        if (b[30:23] == 8'd0) begin
            if (frac == 0)
                return sgn;
            ex = 1 - 127 + 1023;
            while (frac[23] == 1'b0) begin
                frac = frac << 1;
                ex--;
            end
            frac[23] = 1'b0;
            return sgn | (64'(ex) << 52) | (frac << 29);
        end
        ex = int'(b[30:23]) - 127 + 1023;
        return sgn | (64'(ex) << 52) | (frac << 29);
    endfunction

    function automatic t_out_item convert_sample(t_in_item it);
        t_out_item   res;
        logic [63:0] val;
        logic        sat;
        int          n;
        sat = 1'b0;
        case (fmt_reg)
            FMT_INT16: begin
                val = scale_to_pcm(it.sample_bits, 32767.0 + 0.49999, 16, sat);
                n = 2;
            end
            FMT_INT24: begin
                val = scale_to_pcm(it.sample_bits, 8388607.0 + 0.49999, 24, sat);
                n = 3;
            end
            FMT_INT32: begin
                val = scale_to_pcm(it.sample_bits, 2147483647.0 + 0.49999, 32, sat);
                n = 4;
            end
            FMT_F64: begin
                val = widen_to_f64(it.sample_bits);
                n = 8;
            end
            default: begin
                // float32 and the unused codes pass the bits through
                val = {32'd0, it.sample_bits};
                n = 4;
            end
        endcase
        res.packed_bytes = '0;
        if (be_reg) begin
            for (int i = 0; i < n; i++)
                res.packed_bytes[8*i +: 8] = val[8*(n-1-i) +: 8];
        end else begin
            res.packed_bytes = val;
        end
        res.byte_count = 4'(n);
        res.overflow = sat;
        res.end_of_block_out = it.end_of_block;
        return res;
    endfunction

    // Result checker: compare each strobed item with the oldest expectation.
    always @(negedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pcm_expected.size() == 0) begin
                $error("unexpected result %h", o_out_item);
                mismatch_count++;
            end else begin
                want = pcm_expected.pop_front();
                if (o_out_item.packed_bytes !== want.packed_bytes) begin
                    $error("packed_bytes: expected %h, got %h",
                           want.packed_bytes, o_out_item.packed_bytes);
                    mismatch_count++;
                end
                if (o_out_item.byte_count !== want.byte_count) begin
                    $error("byte_count: expected %0d, got %0d",
                           want.byte_count, o_out_item.byte_count);
                    mismatch_count++;
                end
                if (o_out_item.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b",
                           want.overflow, o_out_item.overflow);
                    mismatch_count++;
                end
                if (o_out_item.end_of_block_out !== want.end_of_block_out) begin
                    $error("end_of_block_out: expected %0b, got %0b",
                           want.end_of_block_out, o_out_item.end_of_block_out);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_float_sample_to_pcm_converter_unit: done, errors");
            $finish;
        end
    end

    // Send one sample; hold start until accepted, then, if allowed, take a random gap.
    task automatic send_sample(logic [31:0] bits, logic eob, bit allow_gap);
        t_in_item it;
        int       gap;
        it.sample_bits = bits;
        it.end_of_block = eob;
        i_in_item <= it;
        start <= 1'b1;
        do @(posedge i_clk); while (busy_at_edge);
        pcm_expected.push_back(convert_sample(it));
        gap = allow_gap ? $urandom_range(0, 12) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Let the pipeline empty before touching registers.
    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge i_clk);
        while (pcm_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [1:0] idx, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FORMAT: fmt_reg = data[2:0];
            REG_ENDIAN: be_reg = data[0];
            REG_CLAMP:  clamp_reg = data[0];
            default: ;
        endcase
    endtask

    task automatic set_mode(logic [2:0] fmt, logic be, logic clamp);
        drain_pipeline();
        apb_write(REG_FORMAT, {$urandom} & ~32'h7 | 32'(fmt));
        apb_write(REG_ENDIAN, {$urandom} & ~32'h1 | 32'(be));
        apb_write(REG_CLAMP, {$urandom} & ~32'h1 | 32'(clamp));
    endtask

    // Corner samples: zeros, unity, just below unity, infinities, NaNs,
    // subnormals, the largest finite value, and a pattern with every bit set.
    logic [31:0] corner_samples[16] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h3F7F_FFFF, 32'h3F00_0000, 32'h3FC0_0000, 32'hC000_0000,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h7F80_0001,
        32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF, 32'hFFFF_FFFF
    };

    // Directed pass: each corner sample under each format, endian and clamp.
    task automatic test_corner_samples();
        for (int f = 0; f < 6; f++) begin
            for (int m = 0; m < 4; m++) begin
                set_mode(f == 5 ? 3'd7 : 3'(f), m[0], m[1]);
                foreach (corner_samples[i])
                    send_sample(corner_samples[i], i[0], 1'b0);
            end
        end
    endtask

    // Bias random samples toward the interesting region around unity.
    function automatic logic [31:0] random_sample();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(0, 5))
            0, 1: b[30:23] = 8'(125 + $urandom_range(0, 3));  // near +-1
            2:    b[30:23] = 8'($urandom_range(100, 127));      // in range
            3:    b[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            4:    b[30:23] = 8'($urandom_range(128, 160));      // beyond full scale
            default: ;
        endcase
        return b;
    endfunction

    // Random pass: blocks of samples, each under a fresh random setting.
    task automatic test_random_stream();
        for (int blk = 0; blk < 28; blk++) begin
            set_mode(3'($urandom_range(0, 7)), 1'($urandom), 1'($urandom));
            for (int i = 0; i < 40; i++)
                send_sample(random_sample(), 1'($urandom_range(0, 7) == 0), blk % 4 != 3);
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_samples();
        test_random_stream();
        drain_pipeline();
        if (mismatch_count == 0 && pcm_expected.size() == 0) begin
            $display("tb_float_sample_to_pcm_converter_unit: done, clean");
        end else begin
            $display("tb_float_sample_to_pcm_converter_unit: done, errors");
        end
        $finish;
    end

endmodule
